[rtl/core/deli_pkg.sv]
// Shared types and constants for the drive enable and light interlock.
// No dependencies; imported by every module of the block.
package deli_pkg;

    localparam int SIG_W      = 16;
    localparam int MODE_W     = 3;
    localparam int HOLD_W     = 16;
    localparam int RESEND_W   = 8;
    localparam int DEADBAND_W = 15;
    localparam int BRAKE_W    = 17;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [BRAKE_W-1:0] BRAKE_TICKS_MAX = '1;

    // event kinds carried in s_tuser; the remaining codes are ignored
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK      = 3'd0,
        MODE_RELEASE   = 3'd1,
        MODE_EMERGENCY = 3'd2,
        MODE_STEERING  = 3'd3,
        MODE_THROTTLE  = 3'd4
    } mode_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AUTO_RELEASE = 2'd0,
        CFG_BRAKE_HOLD   = 2'd1,
        CFG_RESEND       = 2'd2,
        CFG_DEADBAND     = 2'd3
    } cfg_idx_t;

    // the auto-release bit only loads interlock state, so it is not kept here
    typedef struct packed {
        logic [HOLD_W-1:0]     brake_hold;
        logic [RESEND_W-1:0]   resend;
        logic [DEADBAND_W-1:0] deadband;
    } cfg_t;

    typedef struct packed {
        logic                    release_flag;
        logic                    emergency_ok;
        logic                    was_running;
        logic                    driving;
        logic                    status_dirty;
        logic signed [SIG_W-1:0] throttle_now;
        logic signed [SIG_W-1:0] steering_now;
        logic [RESEND_W-1:0]     throttle_resend;
        logic [RESEND_W-1:0]     steering_resend;
        logic [BRAKE_W-1:0]      brake_ticks;
        logic                    brake_on;
        logic                    reverse_on;
    } state_t;

    typedef struct packed {
        mode_t                   mode;
        logic                    flag_value;
        logic signed [SIG_W-1:0] signal_value;
    } item_t;

    typedef struct packed {
        logic                    brake_light;
        logic                    reverse_light;
        logic                    running;
        logic                    throttle_valid;
        logic signed [SIG_W-1:0] throttle_out;
        logic                    steering_valid;
        logic signed [SIG_W-1:0] steer_pos;
    } res_t;

endpackage

[rtl/core/deli_step.sv]
// Next-state and result logic for one event of the interlock.
// Purely combinational; depends on deli_pkg.
module deli_step
    import deli_pkg::*;
(
    input  cfg_t   cfg,
    input  state_t cur,
    input  item_t  item,
    output state_t nxt,
    output logic   emit,
    output res_t   res
);

    logic signed [SIG_W-1:0] v;
    logic signed [SIG_W-1:0] c;
    logic [BRAKE_W-1:0]      thr_diff;
    logic [BRAKE_W-1:0]      str_diff;
    logic [BRAKE_W-1:0]      deadband_ext;

    // magnitude of the difference of two signed values
    function automatic logic [BRAKE_W-1:0] absdiff(
        input logic signed [SIG_W-1:0] a,
        input logic signed [SIG_W-1:0] b
    );
        logic signed [BRAKE_W-1:0] d;
        d = {a[SIG_W-1], a} - {b[SIG_W-1], b};
        absdiff = d[BRAKE_W-1] ? BRAKE_W'(-d) : BRAKE_W'(d);
    endfunction

    assign v            = item.signal_value;
    assign c            = cur.throttle_now;
    assign thr_diff     = absdiff(c, v);
    assign str_diff     = absdiff(cur.steering_now, v);
    assign deadband_ext = {{(BRAKE_W-DEADBAND_W){1'b0}}, cfg.deadband};

    // event dispatch
    always_comb
    begin
        nxt  = cur;
        emit = 1'b0;
        res  = '0;
        case (item.mode)
            MODE_TICK:
            begin
                // re-evaluate drive status after a flag change
                if (cur.status_dirty)
                begin
                    nxt.status_dirty = 1'b0;
                    nxt.driving      = cur.release_flag && cur.emergency_ok;
                    if (!nxt.driving)
                    begin
                        nxt.throttle_now    = '0;
                        nxt.throttle_resend = cfg.resend;
                        nxt.steering_now    = '0;
                        nxt.steering_resend = cfg.resend;
                        nxt.brake_on        = 1'b1;
                    end
                    else
                    begin
                        nxt.was_running = 1'b1;
                        nxt.brake_on    = 1'b0;
                    end
                end
                // enabled tick: brake hold counter, lights and pending values
                if (nxt.release_flag || nxt.was_running)
                begin
                    emit = 1'b1;
                    if (nxt.brake_on && nxt.brake_ticks != BRAKE_TICKS_MAX)
                        nxt.brake_ticks = nxt.brake_ticks + 1'b1;
                    if (nxt.brake_ticks > {1'b0, cfg.brake_hold})
                        nxt.brake_on = 1'b0;
                    res.brake_light   = nxt.brake_on;
                    res.reverse_light = nxt.reverse_on;
                    res.running       = nxt.driving;
                    if (nxt.throttle_resend != '0)
                    begin
                        nxt.throttle_resend = nxt.throttle_resend - 1'b1;
                        res.throttle_valid  = 1'b1;
                    end
                    res.throttle_out = nxt.throttle_now;
                    if (nxt.steering_resend != '0)
                    begin
                        nxt.steering_resend = nxt.steering_resend - 1'b1;
                        res.steering_valid  = 1'b1;
                    end
                    res.steer_pos = nxt.steering_now;
                end
            end
            MODE_RELEASE:
            begin
                if (cur.release_flag != item.flag_value)
                begin
                    nxt.release_flag = item.flag_value;
                    nxt.status_dirty = 1'b1;
                end
            end
            MODE_EMERGENCY:
            begin
                if (cur.emergency_ok != item.flag_value)
                begin
                    nxt.emergency_ok = item.flag_value;
                    nxt.status_dirty = 1'b1;
                end
            end
            MODE_STEERING:
            begin
                if (cur.driving && str_diff > deadband_ext)
                begin
                    nxt.steering_now    = v;
                    nxt.steering_resend = cfg.resend;
                end
            end
            MODE_THROTTLE:
            begin
                // lights follow the sign and direction of the change
                if (cur.driving)
                begin
                    if (thr_diff > deadband_ext)
                    begin
                        if (!v[SIG_W-1] && v < c)
                        begin
                            nxt.brake_on    = 1'b1;
                            nxt.brake_ticks = '0;
                        end
                        else if (!v[SIG_W-1])
                        begin
                            if (!c[SIG_W-1])
                                nxt.brake_on = 1'b0;
                            else
                            begin
                                nxt.brake_on    = 1'b1;
                                nxt.brake_ticks = '0;
                            end
                        end
                        if (v[SIG_W-1])
                        begin
                            nxt.reverse_on = 1'b1;
                            if (v > c)
                            begin
                                nxt.brake_on    = 1'b1;
                                nxt.brake_ticks = '0;
                            end
                            else
                                nxt.brake_on = 1'b0;
                        end
                        else
                            nxt.reverse_on = 1'b0;
                        nxt.throttle_now    = v;
                        nxt.throttle_resend = cfg.resend;
                    end
                    else
                        nxt.brake_on = 1'b0;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

[rtl/core/drive_enable_light_interlock_top.sv]
// Drive enable interlock with brake and reverse lights, top level.
// An event is registered in the input stage; a tick's result then moves into the
// result register, on m_tdata with m_tvalid, once that register is free or being taken.
// Throughput: one event per cycle; s_tready drops only while an event waits
// behind a result that m_tready has not yet taken.
// Reset: configuration and interlock state return to their reset values.
// Depends on deli_pkg and deli_step.
module drive_enable_light_interlock_top
    import deli_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // flag_value[0], signal_value[16:1]
    input  logic [MODE_W-1:0]     s_tuser,   // mode[2:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // brake_light[0], reverse_light[1],
                                             // running[2], throttle_valid[3],
                                             // throttle_out[19:4],
                                             // steering_valid[20],
                                             // steer_pos[36:21]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    state_t               state_reg;
    state_t               state_next;
    state_t               step_state;
    logic                 in_valid_reg;
    item_t                in_item_reg;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 advance;
    logic                 emit;
    res_t                 res;
    logic                 cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // the input stage moves on when the result register is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    deli_step u_step (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .item (in_item_reg),
        .nxt  (step_state),
        .emit (emit),
        .res  (res)
    );

    // configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                // auto-release only loads the interlock state below
                CFG_AUTO_RELEASE: cfg_next = cfg_reg;
                CFG_BRAKE_HOLD:   cfg_next.brake_hold   = cfg_data[HOLD_W-1:0];
                CFG_RESEND:       cfg_next.resend       = cfg_data[RESEND_W-1:0];
                CFG_DEADBAND:     cfg_next.deadband     = cfg_data[DEADBAND_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // state update; an auto-release write also loads the release and run marks
    always_comb
    begin
        state_next = advance ? step_state : state_reg;
        if (cfg_write && cfg_idx_t'(cfg_index) == CFG_AUTO_RELEASE)
        begin
            state_next.release_flag = cfg_data[0];
            state_next.was_running  = cfg_data[0];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.brake_hold        <= HOLD_W'(10);
            cfg_reg.resend            <= RESEND_W'(2);
            cfg_reg.deadband          <= DEADBAND_W'(1);
            state_reg.release_flag    <= 1'b0;
            state_reg.emergency_ok    <= 1'b1;
            state_reg.was_running     <= 1'b0;
            state_reg.driving         <= 1'b0;
            state_reg.status_dirty    <= 1'b1;
            state_reg.throttle_now    <= '0;
            state_reg.steering_now    <= '0;
            state_reg.throttle_resend <= '0;
            state_reg.steering_resend <= '0;
            state_reg.brake_ticks     <= '0;
            state_reg.brake_on        <= 1'b0;
            state_reg.reverse_on      <= 1'b0;
            in_valid_reg              <= 1'b0;
            out_valid_reg             <= 1'b0;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            state_reg <= state_next;
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance && emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.mode         <= mode_t'(s_tuser);
            in_item_reg.flag_value   <= s_tdata[0];
            in_item_reg.signal_value <= s_tdata[SIG_W:1];
        end
        if (advance && emit)
            out_data_reg <= {3'b000, res.steer_pos, res.steering_valid,
                             res.throttle_out, res.throttle_valid, res.running,
                             res.reverse_light, res.brake_light};
    end

endmodule

[rtl/core/deli_checker.sv]
// Port-level checks for the interlock top level, bound to every instance.
// Depends on deli_pkg and drive_enable_light_interlock_top.
module deli_checker
    import deli_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input backpressure only comes from a stalled result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // a fresh result follows an input transaction through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a matching input transaction");

    // when driving is off, throttle and steering are zero
    a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[2] |-> m_tdata[19:4] == '0 && m_tdata[36:21] == '0)
        else $error("nonzero value while stopped");

endmodule

bind drive_enable_light_interlock_top deli_checker u_deli_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for the drive enable and light interlock top level.
// Depends on deli_pkg and drive_enable_light_interlock_top; predicts each
// result from its own model of the interlock and checks it on m_tdata.
`timescale 1ns / 100ps

module testbench;
    import deli_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 6;
    localparam int REPORT_MAX    = 10;
    localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = MODE_THROTTLE + 3'd1;
    localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = '1;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // flag_value[0], signal_value[16:1]
    logic [MODE_W-1:0]     s_tuser;   // mode[2:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // brake_light[0], reverse_light[1], running[2],
                                      // throttle_valid[3], throttle_out[19:4],
                                      // steering_valid[20], steer_pos[36:21]
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predicted interlock registers and state
    cfg_t   regs;
    state_t ilk;
    res_t   expected_results[$];

    int  mismatches;
    int  cycles;
    bit  calm;

    drive_enable_light_interlock_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, none in calm stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // sink side stalls
    initial
    begin
        int stall;
        m_tready = 1'b0;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                stall--;
            end
            else
            begin
                m_tready = 1'b1;
                stall = pick_gap();
            end
        end
    end

    function automatic int gap_of(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic void brake_restart();
        ilk.brake_on    = 1'b1;
        ilk.brake_ticks = '0;
    endfunction

    // apply one event to the predicted state; returns 1 when a result is due
    function automatic bit advance_interlock(input logic [MODE_W-1:0] mode,
                                             input logic flag,
                                             input logic signed [SIG_W-1:0] value,
                                             output res_t r);
        int cur;
        int nxt;
        r = '0;
        nxt = value;
        case (mode)
            MODE_TICK:
            begin
                // status re-evaluation after a flag change
                if (ilk.status_dirty)
                begin
                    ilk.status_dirty = 1'b0;
                    ilk.driving = ilk.release_flag && ilk.emergency_ok;
                    if (!ilk.driving)
                    begin
                        ilk.throttle_now    = '0;
                        ilk.steering_now    = '0;
                        ilk.throttle_resend = regs.resend;
                        ilk.steering_resend = regs.resend;
                        ilk.brake_on        = 1'b1;
                    end
                    else
                    begin
                        ilk.was_running = 1'b1;
                        ilk.brake_on    = 1'b0;
                    end
                end
                if (!(ilk.release_flag || ilk.was_running))
                    return 1'b0;
                // brake hold counter, saturating
                if (ilk.brake_on && ilk.brake_ticks != BRAKE_TICKS_MAX)
                    ilk.brake_ticks = ilk.brake_ticks + 1'b1;
                if (ilk.brake_ticks > {1'b0, regs.brake_hold})
                    ilk.brake_on = 1'b0;
                r.brake_light   = ilk.brake_on;
                r.reverse_light = ilk.reverse_on;
                r.running       = ilk.driving;
                r.throttle_out  = ilk.throttle_now;
                r.steer_pos     = ilk.steering_now;
                if (ilk.throttle_resend != 0)
                begin
                    ilk.throttle_resend--;
                    r.throttle_valid = 1'b1;
                end
                if (ilk.steering_resend != 0)
                begin
                    ilk.steering_resend--;
                    r.steering_valid = 1'b1;
                end
                return 1'b1;
            end
            MODE_RELEASE:
            begin
                if (ilk.release_flag != flag)
                begin
                    ilk.release_flag = flag;
                    ilk.status_dirty = 1'b1;
                end
            end
            MODE_EMERGENCY:
            begin
                if (ilk.emergency_ok != flag)
                begin
                    ilk.emergency_ok = flag;
                    ilk.status_dirty = 1'b1;
                end
            end
            MODE_STEERING:
            begin
                cur = $signed(ilk.steering_now);
                if (ilk.driving && gap_of(cur, nxt) > int'(regs.deadband))
                begin
                    ilk.steering_now    = value;
                    ilk.steering_resend = regs.resend;
                end
            end
            MODE_THROTTLE:
            begin
                cur = $signed(ilk.throttle_now);
                if (ilk.driving)
                begin
                    if (gap_of(cur, nxt) > int'(regs.deadband))
                    begin
                        // lights from sign and direction of the change
                        if (nxt >= 0 && nxt < cur)
                            brake_restart();
                        else if (nxt >= 0)
                        begin
                            if (cur >= 0)
                                ilk.brake_on = 1'b0;
                            else
                                brake_restart();
                        end
                        if (nxt < 0)
                        begin
                            ilk.reverse_on = 1'b1;
                            if (nxt > cur)
                                brake_restart();
                            else
                                ilk.brake_on = 1'b0;
                        end
                        else
                            ilk.reverse_on = 1'b0;
                        ilk.throttle_now    = value;
                        ilk.throttle_resend = regs.resend;
                    end
                    else
                        ilk.brake_on = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        return 1'b0;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.brake_light    = m_tdata[0];
            got.reverse_light  = m_tdata[1];
            got.running        = m_tdata[2];
            got.throttle_valid = m_tdata[3];
            got.throttle_out   = m_tdata[19:4];
            got.steering_valid = m_tdata[20];
            got.steer_pos      = m_tdata[36:21];
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: %p", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.brake_light    !== want.brake_light    ||
                    got.reverse_light  !== want.reverse_light  ||
                    got.running        !== want.running        ||
                    got.throttle_valid !== want.throttle_valid ||
                    got.throttle_out   !== want.throttle_out   ||
                    got.steering_valid !== want.steering_valid ||
                    got.steer_pos      !== want.steer_pos)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("result mismatch at cycle %0d: expected %p, got %p",
                                 cycles, want, got);
                end
            end
        end
    end

    // send one event; returns at a falling edge with s_tvalid possibly still high
    task automatic send_event(input logic [MODE_W-1:0] mode, input logic flag,
                              input logic signed [SIG_W-1:0] value);
        res_t r;
        int   gap;
        s_tuser  = mode;
        s_tdata  = S_TDATA_W'({value, flag});
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        if (advance_interlock(mode, flag, value, r))
            expected_results.push_back(r);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // stop the stream, wait for every expected result, then let the outputs settle
    task automatic drain();
        s_tvalid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write transaction
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_AUTO_RELEASE:
            begin
                ilk.release_flag  = data[0];
                ilk.was_running   = data[0];
            end
            CFG_BRAKE_HOLD: regs.brake_hold = data[HOLD_W-1:0];
            CFG_RESEND:     regs.resend     = data[RESEND_W-1:0];
            CFG_DEADBAND:   regs.deadband   = data[DEADBAND_W-1:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // directed events under the reset configuration
    task automatic test_directed_events();
        // tick before any release: no result, status goes stopped
        send_event(MODE_TICK, 1'b0, '0);
        send_event(MODE_UNUSED_FIRST, 1'b1, 16'sh7fff);
        send_event(MODE_UNUSED_LAST, 1'b0, 16'sh8000);
        // values while not driving are ignored
        send_event(MODE_THROTTLE, 1'b0, 16'sh7fff);
        send_event(MODE_STEERING, 1'b0, 16'sh8000);
        // release, then same levels again
        send_event(MODE_RELEASE, 1'b1, '0);
        send_event(MODE_RELEASE, 1'b1, '0);
        send_event(MODE_EMERGENCY, 1'b1, '0);
        send_event(MODE_TICK, 1'b0, '0);
        // throttle extremes and reverse
        send_event(MODE_THROTTLE, 1'b0, 16'sh7fff);
        send_event(MODE_TICK, 1'b0, '0);
        send_event(MODE_THROTTLE, 1'b1, 16'sh8000);
        send_event(MODE_TICK, 1'b0, '0);
        // throttle change within the deadband, then steering extremes
        send_event(MODE_THROTTLE, 1'b0, 16'sh8001);
        send_event(MODE_STEERING, 1'b1, 16'sh8000);
        send_event(MODE_STEERING, 1'b0, 16'sh7fff);
        send_event(MODE_TICK, 1'b0, '0);
        // forward slow-down sets the brake light
        send_event(MODE_THROTTLE, 1'b0, 16'sd100);
        send_event(MODE_THROTTLE, 1'b0, 16'sd50);
        send_event(MODE_TICK, 1'b0, '0);
        // emergency stop, then release dropped while was-running holds ticks on
        send_event(MODE_EMERGENCY, 1'b0, '0);
        send_event(MODE_TICK, 1'b0, '0);
        send_event(MODE_EMERGENCY, 1'b1, '0);
        send_event(MODE_RELEASE, 1'b0, '0);
        send_event(MODE_TICK, 1'b0, '0);
        send_event(MODE_TICK, 1'b0, '0);
        drain();
    endtask

    // random traffic under one register setting
    task automatic test_random_traffic(input int n, input logic start,
                                       input logic [HOLD_W-1:0] hold,
                                       input logic [RESEND_W-1:0] resend,
                                       input logic [DEADBAND_W-1:0] band,
                                       input bit quiet);
        int sent;
        int r;
        int span;
        int base;
        logic flag;
        logic signed [SIG_W-1:0] value;
        logic [MODE_W-1:0] mode;
        write_reg(CFG_BRAKE_HOLD, hold);
        write_reg(CFG_RESEND, resend);
        write_reg(CFG_DEADBAND, {logic'($urandom_range(0, 1)), band});
        write_reg(CFG_AUTO_RELEASE, {15'($urandom), start});
        calm = quiet;
        sent = 0;
        while (sent < n)
        begin
            r = $urandom_range(0, 99);
            flag = ($urandom_range(0, 9) < 8);
            span = int'(regs.deadband) + 3;
            if (r < 5 && !ilk.driving)
            begin
                // well-formed enable sequence
                send_event(MODE_RELEASE, 1'b1, 16'($urandom));
                send_event(MODE_EMERGENCY, 1'b1, 16'($urandom));
                send_event(MODE_TICK, flag, 16'($urandom));
                sent += 3;
                continue;
            end
            if (r < 40)
                mode = MODE_TICK;
            else if (r < 65)
                mode = MODE_THROTTLE;
            else if (r < 80)
                mode = MODE_STEERING;
            else if (r < 87)
                mode = MODE_RELEASE;
            else if (r < 94)
                mode = MODE_EMERGENCY;
            else
                mode = MODE_W'($urandom_range(MODE_UNUSED_LAST, MODE_UNUSED_FIRST));
            // values near the current one, around the deadband, or anywhere
            base = (mode == MODE_STEERING) ? int'($signed(ilk.steering_now))
                                           : int'($signed(ilk.throttle_now));
            if ($urandom_range(0, 2) == 0)
                value = 16'($urandom);
            else
                value = 16'(base + int'($urandom_range(0, 2 * span)) - span);
            send_event(mode, flag, value);
            if (mode <= MODE_THROTTLE)
                sent++;
        end
        drain();
        calm = 1'b0;
    endtask

    // stimulus sequence
    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = MODE_TICK;
        cfg_valid = 1'b0;
        cfg_index = CFG_AUTO_RELEASE;
        cfg_data  = '0;
        calm      = 1'b0;

        // reset values of the registers and the interlock
        regs = '0;
        regs.brake_hold = 16'd10;
        regs.resend     = 8'd2;
        regs.deadband   = 15'd1;
        ilk = '0;
        ilk.emergency_ok = 1'b1;
        ilk.status_dirty = 1'b1;

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_events();
        test_random_traffic(110, 1'b1, '0, '0, '0, 1'b1);
        test_random_traffic(110, 1'b0, '1, '1, '1, 1'b0);
        test_random_traffic(120, logic'($urandom_range(0, 1)), 16'd3, 8'd4, 15'd20, 1'b0);
        test_random_traffic(110, 1'b1, 16'($urandom_range(0, 15)),
                            8'($urandom_range(0, 6)), 15'($urandom_range(0, 200)), 1'b0);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[drive_enable_light_interlock_top.f]
rtl/core/deli_pkg.sv
rtl/core/deli_step.sv
rtl/core/drive_enable_light_interlock_top.sv
rtl/core/deli_checker.sv
tb/testbench.sv
